// ===== hw/rtl/phsc_pkg.sv =====
// ----------------------------------------------------------------------------
// phsc_pkg: shared types and constants of the hazard stall counter
// RISC-V opcode values, instruction field positions and the decode struct.
// ----------------------------------------------------------------------------
package phsc_pkg;

   localparam int INSTR_BITS = 32;
   localparam int TOTAL_BITS = 48;
   localparam int OPCODE_BITS = 7;
   localparam int REG_BITS = 5;
   localparam int PENALTY_BITS = 2;

   localparam int RD_LSB = 7;
   localparam int RS1_LSB = 15;
   localparam int RS2_LSB = 20;

   typedef logic [INSTR_BITS-1:0] instr_type;
   typedef logic [TOTAL_BITS-1:0] total_type;
   typedef logic [OPCODE_BITS-1:0] opcode_type;
   typedef logic [REG_BITS-1:0] reg_type;
   typedef logic [PENALTY_BITS-1:0] penalty_type;

   localparam opcode_type OPC_LOAD = 7'h03;
   localparam opcode_type OPC_IMM = 7'h13;
   localparam opcode_type OPC_STORE = 7'h23;
   localparam opcode_type OPC_REG = 7'h33;
   localparam opcode_type OPC_BRANCH = 7'h63;
   localparam opcode_type OPC_JALR = 7'h67;
   localparam opcode_type OPC_JAL = 7'h6F;

   localparam penalty_type PEN_NONE = 2'd0;
   localparam penalty_type PEN_JAL = 2'd1;
   localparam penalty_type PEN_FLUSH = 2'd2;

   typedef struct packed {
      logic        bubble;
      logic        redirect;
      penalty_type penalty;
      reg_type     load_dest;
   } hazard_type;

endpackage

// ===== hw/rtl/phsc_ifs.sv =====
// ----------------------------------------------------------------------------
// phsc_ifs: request and response channels of the hazard stall counter
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface phsc_req_if;
   logic                valid;
   logic                ready;
   phsc_pkg::instr_type instruction;
   logic                redirected;

   modport source (output valid, output instruction, output redirected, input ready);
   modport sink (input valid, input instruction, input redirected, output ready);
endinterface

interface phsc_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  load_use_bubble;
   phsc_pkg::penalty_type control_penalty;
   phsc_pkg::total_type   instruction_total;
   phsc_pkg::total_type   load_use_total;
   phsc_pkg::total_type   control_event_total;
   phsc_pkg::total_type   control_cycle_total;
   phsc_pkg::total_type   cycle_total;

   modport source (
      output valid, output load_use_bubble, output control_penalty,
      output instruction_total, output load_use_total, output control_event_total,
      output control_cycle_total, output cycle_total, input ready
   );
   modport sink (
      input valid, input load_use_bubble, input control_penalty,
      input instruction_total, input load_use_total, input control_event_total,
      input control_cycle_total, input cycle_total, output ready
   );
endinterface

// ===== hw/rtl/phsc_decode.sv =====
// ----------------------------------------------------------------------------
// phsc_decode: operand decode and hazard classification
// Finds load-use hits against the pending load and the redirect penalty.
// ----------------------------------------------------------------------------
module phsc_decode (
   input  phsc_pkg::instr_type  instruction,
   input  logic                 redirected,
   input  phsc_pkg::reg_type    pend_dest,
   output phsc_pkg::hazard_type hazard
);

   phsc_pkg::opcode_type opcode;
   phsc_pkg::reg_type    rs1;
   phsc_pkg::reg_type    rs2;
   phsc_pkg::reg_type    rd;
   logic                 use1;
   logic                 use2;

   assign opcode = instruction[phsc_pkg::OPCODE_BITS-1:0];
   assign rs1 = instruction[phsc_pkg::RS1_LSB +: phsc_pkg::REG_BITS];
   assign rs2 = instruction[phsc_pkg::RS2_LSB +: phsc_pkg::REG_BITS];
   assign rd = instruction[phsc_pkg::RD_LSB +: phsc_pkg::REG_BITS];

   always_comb begin
      use1 = 1'b0;
      use2 = 1'b0;
      unique case (opcode) inside
         phsc_pkg::OPC_REG, phsc_pkg::OPC_STORE, phsc_pkg::OPC_BRANCH: begin
            use1 = 1'b1;
            use2 = 1'b1;
         end
         phsc_pkg::OPC_IMM, phsc_pkg::OPC_LOAD, phsc_pkg::OPC_JALR: begin
            use1 = 1'b1;
         end
         default: begin
            use1 = 1'b0;
            use2 = 1'b0;
         end
      endcase
   end

   always_comb begin
      hazard.bubble = (pend_dest != '0) &&
                      ((use1 && (rs1 == pend_dest)) || (use2 && (rs2 == pend_dest)));
      hazard.redirect = redirected;
      if (!redirected) begin
         hazard.penalty = phsc_pkg::PEN_NONE;
      end else if (opcode == phsc_pkg::OPC_JAL) begin
         hazard.penalty = phsc_pkg::PEN_JAL;
      end else begin
         hazard.penalty = phsc_pkg::PEN_FLUSH;
      end
      hazard.load_dest = (opcode == phsc_pkg::OPC_LOAD) ? rd : '0;
   end

endmodule

// ===== hw/rtl/phsc_counters.sv =====
// ----------------------------------------------------------------------------
// phsc_counters: pending load register and saturating event counters
// Updates all running totals, including the capped cycle total, per advance.
// ----------------------------------------------------------------------------
module phsc_counters #(
   parameter int STAGE_COUNT = 5,
   parameter int COUNTER_BITS = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  phsc_pkg::hazard_type     hazard,
   output phsc_pkg::reg_type        pend_dest,
   output logic [COUNTER_BITS-1:0]  inst_total,
   output logic [COUNTER_BITS-1:0]  lu_total,
   output logic [COUNTER_BITS-1:0]  ce_total,
   output logic [COUNTER_BITS-1:0]  cc_total,
   output logic [COUNTER_BITS-1:0]  cyc_total
);

   localparam int DELTA_BITS = $clog2(STAGE_COUNT + 4);
   localparam logic [DELTA_BITS-1:0] FILL = DELTA_BITS'(STAGE_COUNT - 1);

   phsc_pkg::reg_type       pend_ff, pend_in;
   logic [COUNTER_BITS-1:0] inst_ff, inst_in;
   logic [COUNTER_BITS-1:0] lu_ff, lu_in;
   logic [COUNTER_BITS-1:0] ce_ff, ce_in;
   logic [COUNTER_BITS-1:0] cc_ff, cc_in;
   logic [COUNTER_BITS-1:0] cyc_ff, cyc_in;

   logic                    inst_step;
   logic                    lu_step;
   logic                    ce_step;
   logic [COUNTER_BITS:0]   cc_sum;
   phsc_pkg::penalty_type   cc_step;
   logic [DELTA_BITS-1:0]   fill;
   logic [DELTA_BITS-1:0]   delta;
   logic [COUNTER_BITS:0]   cyc_sum;

   always_comb begin
      inst_step = (inst_ff != '1);
      lu_step = hazard.bubble && (lu_ff != '1);
      ce_step = hazard.redirect && (ce_ff != '1);
      cc_sum = {1'b0, cc_ff} + (COUNTER_BITS + 1)'(hazard.penalty);
      if (!cc_sum[COUNTER_BITS]) begin
         cc_step = hazard.penalty;
      end else if (cc_ff == '1) begin
         cc_step = phsc_pkg::PEN_NONE;
      end else begin
         cc_step = phsc_pkg::PEN_JAL;
      end
      fill = (inst_ff == '0) ? FILL : '0;
      delta = DELTA_BITS'(inst_step) + fill + DELTA_BITS'(lu_step) + DELTA_BITS'(cc_step);
      cyc_sum = {1'b0, cyc_ff} + (COUNTER_BITS + 1)'(delta);
   end

   always_comb begin
      pend_in = hazard.load_dest;
      inst_in = inst_ff + COUNTER_BITS'(inst_step);
      lu_in = lu_ff + COUNTER_BITS'(lu_step);
      ce_in = ce_ff + COUNTER_BITS'(ce_step);
      cc_in = cc_sum[COUNTER_BITS] ? '1 : cc_sum[COUNTER_BITS-1:0];
      cyc_in = cyc_sum[COUNTER_BITS] ? '1 : cyc_sum[COUNTER_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         inst_ff <= '0;
         lu_ff <= '0;
         ce_ff <= '0;
         cc_ff <= '0;
         cyc_ff <= '0;
      end else if (advance) begin
         pend_ff <= pend_in;
         inst_ff <= inst_in;
         lu_ff <= lu_in;
         ce_ff <= ce_in;
         cc_ff <= cc_in;
         cyc_ff <= cyc_in;
      end
   end

   assign pend_dest = pend_ff;
   assign inst_total = inst_ff;
   assign lu_total = lu_ff;
   assign ce_total = ce_ff;
   assign cc_total = cc_ff;
   assign cyc_total = cyc_ff;

endmodule

// ===== hw/rtl/pipeline_hazard_stall_counter.sv =====
// ----------------------------------------------------------------------------
// pipeline_hazard_stall_counter: load-use and redirect stall accounting
// Input register, then output register; one transaction per cycle while the
// response side is ready, set by the combinational decode and counter update.
// Reset clears the counters, the pending load and both valid flags.
// ----------------------------------------------------------------------------
module pipeline_hazard_stall_counter #(
   parameter int STAGE_COUNT = 5,
   parameter int COUNTER_BITS = 48
) (
   input logic         clock,
   input logic         reset,
   phsc_req_if.sink    req_chan,
   phsc_rsp_if.source  rsp_chan
);

   logic                  in_valid_ff, in_valid_in;
   phsc_pkg::instr_type   instr_ff, instr_in;
   logic                  redir_ff, redir_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  bubble_ff, bubble_in;
   phsc_pkg::penalty_type penalty_ff, penalty_in;

   logic                    accept;
   logic                    advance;
   phsc_pkg::hazard_type    hazard;
   phsc_pkg::reg_type       pend_dest;
   logic [COUNTER_BITS-1:0] inst_total;
   logic [COUNTER_BITS-1:0] lu_total;
   logic [COUNTER_BITS-1:0] ce_total;
   logic [COUNTER_BITS-1:0] cc_total;
   logic [COUNTER_BITS-1:0] cyc_total;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      instr_in = req_chan.instruction;
      redir_in = req_chan.redirected;
      out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      bubble_in = hazard.bubble;
      penalty_in = hazard.penalty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         instr_ff <= instr_in;
         redir_ff <= redir_in;
      end
      if (advance) begin
         bubble_ff <= bubble_in;
         penalty_ff <= penalty_in;
      end
   end

   phsc_decode u_decode (
      .instruction (instr_ff),
      .redirected  (redir_ff),
      .pend_dest   (pend_dest),
      .hazard      (hazard)
   );

   phsc_counters #(
      .STAGE_COUNT  (STAGE_COUNT),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_counters (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .hazard     (hazard),
      .pend_dest  (pend_dest),
      .inst_total (inst_total),
      .lu_total   (lu_total),
      .ce_total   (ce_total),
      .cc_total   (cc_total),
      .cyc_total  (cyc_total)
   );

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.load_use_bubble = bubble_ff;
   assign rsp_chan.control_penalty = penalty_ff;
   assign rsp_chan.instruction_total = phsc_pkg::total_type'(inst_total);
   assign rsp_chan.load_use_total = phsc_pkg::total_type'(lu_total);
   assign rsp_chan.control_event_total = phsc_pkg::total_type'(ce_total);
   assign rsp_chan.control_cycle_total = phsc_pkg::total_type'(cc_total);
   assign rsp_chan.cycle_total = phsc_pkg::total_type'(cyc_total);

`ifndef SYNTH
   a_inst_count_step: assert property (@(posedge clock) disable iff (reset)
      (advance && (inst_total != '1)) |=> (inst_total == $past(inst_total) + 1'b1))
      else $error("instruction total did not advance by one");

   a_bubble_needs_load: assert property (@(posedge clock) disable iff (reset)
      (advance && hazard.bubble) |-> (pend_dest != '0))
      else $error("load-use bubble without a pending load");

   a_cycles_cover_insts: assert property (@(posedge clock) disable iff (reset)
      cyc_total >= inst_total)
      else $error("cycle total below instruction total");

   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(cyc_total) && $stable(lu_total))
      else $error("totals changed without a transaction");
`endif

endmodule

// ===== dv/pipeline_hazard_stall_counter_test.sv =====
// ----------------------------------------------------------------------------
// pipeline_hazard_stall_counter_test: self-checking bench of the stall counter
// A short table of hand-picked instruction pairs covers each source-operand
// rule, loads into x0 and every redirect penalty. Then about 600 random
// instructions follow, built mostly as load/consumer pairs. Every response is
// compared field by field with a cycle-free model of the counters, or with the
// fixed values of its table row. The request side runs in bursts with gaps,
// and the response side stalls on a rotating mask.
// ----------------------------------------------------------------------------
module pipeline_hazard_stall_counter_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 600;
   localparam int DRAIN_CYCLES = 8;
   localparam int FILL_CYCLES = 4;
   localparam logic [63:0] COUNT_MAX = 64'hFFFF_FFFF_FFFF;
   localparam phsc_pkg::opcode_type OPC_LUI = 7'h37;

   typedef struct packed {
      logic                  bubble;
      phsc_pkg::penalty_type penalty;
      phsc_pkg::total_type   instructions;
      phsc_pkg::total_type   load_uses;
      phsc_pkg::total_type   redirect_events;
      phsc_pkg::total_type   flush_cycles;
      phsc_pkg::total_type   cycles;
   } stall_report_type;

   typedef struct {
      phsc_pkg::instr_type word;
      logic                redir;
      logic                typed;
      stall_report_type    fixed;
   } stim_row_type;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   failures = 0;
   int   burst_left;
   logic [15:0] stall_mask = 16'hFFFF;
   int   mask_age = 0;

   phsc_pkg::reg_type load_dest;
   logic [63:0]       instr_count;
   logic [63:0]       load_use_count;
   logic [63:0]       event_count;
   logic [63:0]       flush_count;

   stall_report_type expected_reports[$];
   stim_row_type     directed_rows[$];

   phsc_req_if req_chan();
   phsc_rsp_if rsp_chan();

   pipeline_hazard_stall_counter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
      if (a >= COUNT_MAX || COUNT_MAX - a < b) begin
         return COUNT_MAX;
      end
      return a + b;
   endfunction

   function automatic logic reads_register(input phsc_pkg::instr_type word,
                                           input phsc_pkg::reg_type r);
      phsc_pkg::opcode_type op;
      logic                 use1;
      logic                 use2;
      op = word[phsc_pkg::OPCODE_BITS-1:0];
      use1 = op == phsc_pkg::OPC_IMM || op == phsc_pkg::OPC_REG ||
             op == phsc_pkg::OPC_LOAD || op == phsc_pkg::OPC_STORE ||
             op == phsc_pkg::OPC_BRANCH || op == phsc_pkg::OPC_JALR;
      use2 = op == phsc_pkg::OPC_REG || op == phsc_pkg::OPC_STORE ||
             op == phsc_pkg::OPC_BRANCH;
      if (r == '0) begin
         return 1'b0;
      end
      return (use1 && word[phsc_pkg::RS1_LSB +: phsc_pkg::REG_BITS] == r) ||
             (use2 && word[phsc_pkg::RS2_LSB +: phsc_pkg::REG_BITS] == r);
   endfunction

   // advance the counters by one retired instruction
   function automatic stall_report_type account_instruction(input phsc_pkg::instr_type word,
                                                            input logic redir);
      stall_report_type     rep;
      phsc_pkg::opcode_type op;
      logic [63:0]          total;
      op = word[phsc_pkg::OPCODE_BITS-1:0];
      rep = '0;
      if (reads_register(word, load_dest)) begin
         rep.bubble = 1'b1;
         load_use_count = sat_sum(load_use_count, 64'd1);
      end
      if (redir) begin
         rep.penalty = (op == phsc_pkg::OPC_JAL) ? phsc_pkg::PEN_JAL : phsc_pkg::PEN_FLUSH;
         event_count = sat_sum(event_count, 64'd1);
         flush_count = sat_sum(flush_count, 64'(rep.penalty));
      end
      instr_count = sat_sum(instr_count, 64'd1);
      load_dest = (op == phsc_pkg::OPC_LOAD) ? word[phsc_pkg::RD_LSB +: phsc_pkg::REG_BITS] : '0;
      total = sat_sum(instr_count, (instr_count > 0) ? 64'(FILL_CYCLES) : 64'd0);
      total = sat_sum(total, load_use_count);
      total = sat_sum(total, flush_count);
      rep.instructions = instr_count[phsc_pkg::TOTAL_BITS-1:0];
      rep.load_uses = load_use_count[phsc_pkg::TOTAL_BITS-1:0];
      rep.redirect_events = event_count[phsc_pkg::TOTAL_BITS-1:0];
      rep.flush_cycles = flush_count[phsc_pkg::TOTAL_BITS-1:0];
      rep.cycles = total[phsc_pkg::TOTAL_BITS-1:0];
      return rep;
   endfunction

   function automatic phsc_pkg::instr_type encode(input phsc_pkg::opcode_type op,
                                                  input phsc_pkg::reg_type rd,
                                                  input phsc_pkg::reg_type rs1,
                                                  input phsc_pkg::reg_type rs2);
      return {7'b0, rs2, rs1, 3'b0, rd, op};
   endfunction

   function automatic stim_row_type row(input phsc_pkg::instr_type word, input logic redir);
      stim_row_type r;
      r.word = word;
      r.redir = redir;
      r.typed = 1'b0;
      r.fixed = '0;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input phsc_pkg::instr_type word,
                                              input logic redir,
                                              input stall_report_type fixed);
      stim_row_type r;
      r = row(word, redir);
      r.typed = 1'b1;
      r.fixed = fixed;
      return r;
   endfunction

   // mostly loads and their consumers, with raw words as noise
   function automatic phsc_pkg::instr_type random_instruction();
      phsc_pkg::instr_type  word;
      phsc_pkg::opcode_type op;
      int pick;
      word = $urandom();
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         return word;
      end
      case ($urandom_range(0, 8))
         0, 1: op = phsc_pkg::OPC_LOAD;
         2: op = phsc_pkg::OPC_IMM;
         3: op = phsc_pkg::OPC_REG;
         4: op = phsc_pkg::OPC_STORE;
         5: op = phsc_pkg::OPC_BRANCH;
         6: op = phsc_pkg::OPC_JALR;
         7: op = phsc_pkg::OPC_JAL;
         default: op = ($urandom_range(0, 1) == 0) ? OPC_LUI :
                       phsc_pkg::opcode_type'($urandom());
      endcase
      word[phsc_pkg::OPCODE_BITS-1:0] = op;
      if ($urandom_range(0, 1) == 0) begin
         word[phsc_pkg::RS1_LSB +: phsc_pkg::REG_BITS] = load_dest;
      end
      if ($urandom_range(0, 1) == 0) begin
         word[phsc_pkg::RS2_LSB +: phsc_pkg::REG_BITS] = load_dest;
      end
      if (op == phsc_pkg::OPC_LOAD && $urandom_range(0, 5) == 0) begin
         word[phsc_pkg::RD_LSB +: phsc_pkg::REG_BITS] = '0;
      end
      return word;
   endfunction

   function automatic logic random_redirect(input phsc_pkg::instr_type word);
      phsc_pkg::opcode_type op;
      op = word[phsc_pkg::OPCODE_BITS-1:0];
      if (op == phsc_pkg::OPC_BRANCH || op == phsc_pkg::OPC_JAL ||
          op == phsc_pkg::OPC_JALR) begin
         return $urandom_range(0, 1) == 1;
      end
      return $urandom_range(0, 7) == 0;
   endfunction

   task automatic send_item(input stim_row_type r);
      stall_report_type predicted;
      req_chan.valid <= 1'b1;
      req_chan.instruction <= r.word;
      req_chan.redirected <= r.redir;
      do @(posedge clock); while (!req_chan.ready);
      predicted = account_instruction(r.word, r.redir);
      expected_reports.push_back(r.typed ? r.fixed : predicted);
   endtask

   // drop valid for a random gap once the current burst is used up
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin : response_side
      stall_report_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_reports.size() == 0) begin
               $error("response transaction with nothing outstanding");
               failures++;
            end else begin
               want = expected_reports.pop_front();
               check_field("load_use_bubble", 64'(want.bubble), 64'(rsp_chan.load_use_bubble));
               check_field("control_penalty", 64'(want.penalty), 64'(rsp_chan.control_penalty));
               check_field("instruction_total", 64'(want.instructions),
                           64'(rsp_chan.instruction_total));
               check_field("load_use_total", 64'(want.load_uses), 64'(rsp_chan.load_use_total));
               check_field("control_event_total", 64'(want.redirect_events),
                           64'(rsp_chan.control_event_total));
               check_field("control_cycle_total", 64'(want.flush_cycles),
                           64'(rsp_chan.control_cycle_total));
               check_field("cycle_total", 64'(want.cycles), 64'(rsp_chan.cycle_total));
            end
         end
         if (mask_age == 0) begin
            case ($urandom_range(0, 3))
               0: stall_mask = 16'hFFFF;
               1: stall_mask = 16'h0101;
               2: stall_mask = 16'h00FF;
               default: stall_mask = 16'($urandom()) | 16'h0001;
            endcase
            mask_age = $urandom_range(16, 200);
         end else begin
            stall_mask = {stall_mask[0], stall_mask[15:1]};
            mask_age--;
         end
         rsp_chan.ready <= stall_mask[0];
      end
   end

   initial begin
      stim_row_type r;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.instruction = '0;
      req_chan.redirected = 1'b0;
      burst_left = 0;
      load_dest = '0;
      instr_count = 0;
      load_use_count = 0;
      event_count = 0;
      flush_count = 0;

      directed_rows.push_back(typed_row(32'h0000_0000, 1'b0,
                                        '{1'b0, phsc_pkg::PEN_NONE,
                                          48'd1, 48'd0, 48'd0, 48'd0, 48'd5}));
      directed_rows.push_back(typed_row(32'hFFFF_FFFF, 1'b1,
                                        '{1'b0, phsc_pkg::PEN_FLUSH,
                                          48'd2, 48'd0, 48'd1, 48'd2, 48'd8}));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_LOAD, 5'd5, 5'd0, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_REG, 5'd1, 5'd5, 5'd2), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_LOAD, 5'd7, 5'd1, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_STORE, 5'd0, 5'd2, 5'd7), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_LOAD, 5'd31, 5'd31, 5'd31), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_BRANCH, 5'd0, 5'd1, 5'd31), 1'b1));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_LOAD, 5'd3, 5'd0, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_JALR, 5'd1, 5'd3, 5'd0), 1'b1));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_LOAD, 5'd9, 5'd0, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_IMM, 5'd9, 5'd9, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_LOAD, 5'd4, 5'd0, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_LOAD, 5'd6, 5'd4, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_IMM, 5'd1, 5'd0, 5'd6), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_LOAD, 5'd8, 5'd0, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_JAL, 5'd1, 5'd8, 5'd8), 1'b1));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_LOAD, 5'd0, 5'd0, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_REG, 5'd1, 5'd0, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_LOAD, 5'd10, 5'd0, 5'd0), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_IMM, 5'd2, 5'd1, 5'd10), 1'b0));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_REG, 5'd3, 5'd10, 5'd10), 1'b0));
      directed_rows.push_back(row(encode(OPC_LUI, 5'd4, 5'd0, 5'd0), 1'b1));
      directed_rows.push_back(row(32'h0000_0000, 1'b1));
      directed_rows.push_back(row(encode(phsc_pkg::OPC_JAL, 5'd0, 5'd0, 5'd0), 1'b0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i]);
         pace_sender();
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            req_chan.valid <= 1'b0;
            wait_drained();
         end
         r.word = random_instruction();
         r.redir = random_redirect(r.word);
         r.typed = 1'b0;
         r.fixed = '0;
         send_item(r);
         pace_sender();
      end

      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/phsc_pkg.sv
hw/rtl/phsc_ifs.sv
hw/rtl/phsc_decode.sv
hw/rtl/phsc_counters.sv
hw/rtl/pipeline_hazard_stall_counter.sv
dv/pipeline_hazard_stall_counter_test.sv
